@@ sv/mhpq_pkg.sv @@
// Shared types, constants and microprogram for the max-heap priority queue.
// Used by the sequencer, the top level and the bench; depends on nothing.
package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;
  // child index width: right child of the last slot may reach 2*CAPACITY
  localparam int IDX_W    = ADDR_W + 2;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                      func;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count_after;
  } out_t;

  // microprogram step addresses
  typedef enum logic [3:0] {
    U_IDLE   = 4'd0,
    U_DISP   = 4'd1,
    U_INS    = 4'd2,
    U_UP_CHK = 4'd3,
    U_UP_CMP = 4'd4,
    U_PUT    = 4'd5,
    U_FULL   = 4'd6,
    U_DEL    = 4'd7,
    U_DEL_A  = 4'd8,
    U_DN_CHK = 4'd9,
    U_DN_CMP = 4'd10,
    U_EMPTY  = 4'd11,
    U_FIN    = 4'd12
  } upc_e;

  typedef enum logic [3:0] {
    C_TRUE    = 4'd0,
    C_ACCEPT  = 4'd1,
    C_FUNC    = 4'd2,
    C_FULL    = 4'd3,
    C_EMPTY   = 4'd4,
    C_ROOT    = 4'd5,
    C_UPSTOP  = 4'd6,
    C_NOLEFT  = 4'd7,
    C_DNSTOP  = 4'd8,
    C_OUTBUSY = 4'd9
  } cond_e;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_CLR_RES   = 4'd1,
    OP_INS_INIT  = 4'd2,
    OP_RD_PARENT = 4'd3,
    OP_UP_MOVE   = 4'd4,
    OP_PUT       = 4'd5,
    OP_SET_FULL  = 4'd6,
    OP_RD_ROOT   = 4'd7,
    OP_DEL_INIT  = 4'd8,
    OP_RD_KIDS   = 4'd9,
    OP_DN_MOVE   = 4'd10,
    OP_SET_EMPTY = 4'd11,
    OP_LOAD_OUT  = 4'd12
  } dp_op_e;

  // one control word: next step is tgt_t when the condition holds, else tgt_f;
  // with gate_f set the datapath op only runs when the condition is false
  typedef struct packed {
    cond_e  cond;
    upc_e   tgt_t;
    upc_e   tgt_f;
    dp_op_e op;
    logic   gate_f;
    logic   take_in;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic func;
    logic full;
    logic empty;
    logic root;
    logic upstop;
    logic noleft;
    logic dnstop;
    logic outbusy;
  } cond_t;

  // what the sequencer hands to the datapath
  typedef struct packed {
    dp_op_e op;
    logic   take_in;
  } ctrl_t;

  function automatic uword_t ucode_rom(upc_e addr);
    uword_t w;
    unique case (addr)
      U_IDLE:   w = '{C_ACCEPT,  U_DISP,  U_IDLE,   OP_NONE,      1'b0, 1'b1};
      U_DISP:   w = '{C_FUNC,    U_DEL,   U_INS,    OP_CLR_RES,   1'b0, 1'b0};
      U_INS:    w = '{C_FULL,    U_FULL,  U_UP_CHK, OP_INS_INIT,  1'b1, 1'b0};
      U_UP_CHK: w = '{C_ROOT,    U_PUT,   U_UP_CMP, OP_RD_PARENT, 1'b0, 1'b0};
      U_UP_CMP: w = '{C_UPSTOP,  U_PUT,   U_UP_CHK, OP_UP_MOVE,   1'b1, 1'b0};
      U_PUT:    w = '{C_TRUE,    U_FIN,   U_FIN,    OP_PUT,       1'b0, 1'b0};
      U_FULL:   w = '{C_TRUE,    U_FIN,   U_FIN,    OP_SET_FULL,  1'b0, 1'b0};
      U_DEL:    w = '{C_EMPTY,   U_EMPTY, U_DEL_A,  OP_RD_ROOT,   1'b0, 1'b0};
      U_DEL_A:  w = '{C_TRUE,    U_DN_CHK, U_DN_CHK, OP_DEL_INIT, 1'b0, 1'b0};
      U_DN_CHK: w = '{C_NOLEFT,  U_PUT,   U_DN_CMP, OP_RD_KIDS,   1'b0, 1'b0};
      U_DN_CMP: w = '{C_DNSTOP,  U_PUT,   U_DN_CHK, OP_DN_MOVE,   1'b1, 1'b0};
      U_EMPTY:  w = '{C_TRUE,    U_FIN,   U_FIN,    OP_SET_EMPTY, 1'b0, 1'b0};
      U_FIN:    w = '{C_OUTBUSY, U_FIN,   U_IDLE,   OP_LOAD_OUT,  1'b1, 1'b0};
      default:  w = '{C_TRUE,    U_IDLE,  U_IDLE,   OP_NONE,      1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

@@ sv/mhpq_ram.sv @@
// Heap storage: one write port, two registered read ports.
// Generic; no package dependency.
module mhpq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr0_i,
  input  logic [ADDR_W-1:0] raddr1_i,
  output logic [DATA_W-1:0] rdata0_o,
  output logic [DATA_W-1:0] rdata1_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

@@ sv/mhpq_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mhpq_pkg for the control word, flags and program.
module mhpq_seq import mhpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cond_t cond_i,
  output ctrl_t ctrl_o
);

  upc_e   pc_q, pc_d;
  uword_t uword;
  logic   cond_val;

  assign uword = ucode_rom(pc_q);

  always_comb begin
    unique case (uword.cond)
      C_TRUE:    cond_val = 1'b1;
      C_ACCEPT:  cond_val = cond_i.accept;
      C_FUNC:    cond_val = cond_i.func;
      C_FULL:    cond_val = cond_i.full;
      C_EMPTY:   cond_val = cond_i.empty;
      C_ROOT:    cond_val = cond_i.root;
      C_UPSTOP:  cond_val = cond_i.upstop;
      C_NOLEFT:  cond_val = cond_i.noleft;
      C_DNSTOP:  cond_val = cond_i.dnstop;
      C_OUTBUSY: cond_val = cond_i.outbusy;
      default:   cond_val = 1'b0;
    endcase
  end

  always_comb begin
    pc_d           = cond_val ? uword.tgt_t : uword.tgt_f;
    ctrl_o.op      = (uword.gate_f && cond_val) ? OP_NONE : uword.op;
    ctrl_o.take_in = uword.take_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/max_heap_priority_queue.sv @@
// Top level of the max-heap priority queue: heap datapath, storage and sequencer.
// Depends on mhpq_pkg, mhpq_ram and mhpq_seq.
//
// Binary max-heap of up to 1024 signed 32-bit entries. Each input item inserts a
// value (func 0) or removes the maximum (func 1); each gives one result with the
// removed value, a status (delete on empty, insert on full dropped) and the count.
// Items are handled one at a time. Each sift level is a read of the heap memory,
// then a compare and write. A finished result waits in an output register while
// the next item is taken; the last step of that next item stalls until the older
// result has been accepted. The heap memory needs no clearing after reset: only
// entries below the count are ever used.
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  ctrl_t ctrl;
  cond_t cond;

  in_t                       in_q, in_d;
  logic [ADDR_W-1:0]         pos_q, pos_d;
  logic signed [VALUE_W-1:0] mv_q, mv_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [VALUE_W-1:0] rem_q, rem_d;
  status_e                   status_q, status_d;
  out_t                      out_q, out_d;
  logic                      out_valid_q, out_valid_d;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr0, ram_raddr1;
  logic [VALUE_W-1:0]        ram_wdata, rd0, rd1;

  logic                      accept;
  logic [ADDR_W-1:0]         parent_idx;
  logic [IDX_W-1:0]          left_idx, right_idx;
  logic                      has_right, pick_right;
  logic signed [VALUE_W-1:0] best_val;
  logic [ADDR_W-1:0]         best_idx;

  mhpq_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl)
  );

  mhpq_ram #(
    .DATA_W (VALUE_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ram_raddr0),
    .raddr1_i (ram_raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  assign in_ready_o  = ctrl.take_in;
  assign accept      = in_valid_i && ctrl.take_in;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // heap index arithmetic around the current hole
  assign parent_idx = (pos_q - ADDR_W'(1)) >> 1;
  assign left_idx   = IDX_W'({pos_q, 1'b1});
  assign right_idx  = left_idx + IDX_W'(1);
  assign has_right  = right_idx < IDX_W'(cnt_q);
  // equal children: left wins
  assign pick_right = has_right && ($signed(rd1) > $signed(rd0));
  assign best_val   = pick_right ? $signed(rd1) : $signed(rd0);
  assign best_idx   = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

  always_comb begin
    cond.accept  = accept;
    cond.func    = (in_q.func == FUNC_DELETE);
    cond.full    = (cnt_q == CNT_W'(CAPACITY));
    cond.empty   = (cnt_q == '0);
    cond.root    = (pos_q == '0);
    cond.upstop  = !(mv_q > $signed(rd0));
    cond.noleft  = (left_idx >= IDX_W'(cnt_q));
    cond.dnstop  = !(best_val > mv_q);
    cond.outbusy = out_valid_q && !out_ready_i;
  end

  // memory ports
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = mv_q;
    ram_raddr0 = '0;
    ram_raddr1 = '0;
    case (ctrl.op)
      OP_RD_PARENT: ram_raddr0 = parent_idx;
      OP_RD_ROOT: begin
        ram_raddr0 = '0;
        ram_raddr1 = ADDR_W'(cnt_q - CNT_W'(1));
      end
      OP_RD_KIDS: begin
        ram_raddr0 = left_idx[ADDR_W-1:0];
        ram_raddr1 = right_idx[ADDR_W-1:0];
      end
      OP_UP_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = rd0;
      end
      OP_PUT:     ram_we = 1'b1;
      OP_DN_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = best_val;
      end
      default: ;
    endcase
  end

  // register next values
  always_comb begin
    in_d        = accept ? in_i : in_q;
    pos_d       = pos_q;
    mv_d        = mv_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (ctrl.op)
      OP_CLR_RES: begin
        rem_d    = '0;
        status_d = ST_OK;
      end
      OP_INS_INIT: begin
        pos_d = ADDR_W'(cnt_q);
        mv_d  = in_q.value;
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_UP_MOVE:   pos_d    = parent_idx;
      OP_SET_FULL:  status_d = ST_FULL;
      OP_SET_EMPTY: status_d = ST_EMPTY;
      OP_DEL_INIT: begin
        rem_d = $signed(rd0);
        mv_d  = $signed(rd1);
        cnt_d = cnt_q - CNT_W'(1);
        pos_d = '0;
      end
      OP_DN_MOVE: pos_d = best_idx;
      OP_LOAD_OUT: begin
        out_d.removed_value = rem_q;
        out_d.status        = status_q;
        out_d.count_after   = COUNT_W'(cnt_q);
        out_valid_d         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    pos_q    <= pos_d;
    mv_q     <= mv_d;
    rem_q    <= rem_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |->
      (cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q + CNT_W'(1) == $past(cnt_q)))
    else $error("entry count moved by more than one");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_LOAD_OUT) && (status_q == ST_FULL) |-> cnt_q == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_LOAD_OUT) && (status_q == ST_EMPTY) |-> cnt_q == '0)
    else $error("empty status with entries held");

  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == OP_LOAD_OUT |=> out_valid_q)
    else $error("result load did not raise valid");

endmodule

@@ bench/mhpq_checker.sv @@
// Checker for the max-heap priority queue: watches both channels, keeps its own heap
// and compares every result against the oldest prediction. Depends on mhpq_pkg.
module mhpq_checker import mhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   err_cnt_o,
  output int   seen_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
  int   heap_count;
  out_t pending_results [$];
  out_t want;
  out_t pred;

  initial err_cnt_o = 0;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    err_cnt_o = err_cnt_o + 1;
  endtask

  // insert sifts up while the parent is strictly smaller; delete moves the
  // last entry to the root and sifts down toward the larger child (left on ties)
  task automatic apply_heap_op(input in_t item, output out_t res);
    int pos;
    int parent;
    int left;
    int right;
    int best;
    logic signed [VALUE_W-1:0] tmp;
    res = '0;
    res.status = ST_OK;
    if (item.func == FUNC_INSERT) begin
      if (heap_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        heap_mem[heap_count] = item.value;
        pos = heap_count;
        heap_count = heap_count + 1;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_mem[pos] > heap_mem[parent]) begin
            tmp = heap_mem[parent];
            heap_mem[parent] = heap_mem[pos];
            heap_mem[pos] = tmp;
            pos = parent;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = heap_mem[0];
        heap_count = heap_count - 1;
        heap_mem[0] = heap_mem[heap_count];
        pos = 0;
        forever begin
          left = 2 * pos + 1;
          right = left + 1;
          best = pos;
          if (left < heap_count && heap_mem[left] > heap_mem[best]) best = left;
          if (right < heap_count && heap_mem[right] > heap_mem[best]) best = right;
          if (best == pos) break;
          tmp = heap_mem[best];
          heap_mem[best] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = best;
        end
      end
    end
    res.count_after = heap_count[COUNT_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_count = 0;
      pending_results.delete();
      seen_cnt_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_cnt_o <= seen_cnt_o + 1;
        if (pending_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (out_i.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value got %0d want %0d",
                                      out_i.removed_value, want.removed_value));
          if (out_i.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_i.status, want.status));
          if (out_i.count_after !== want.count_after)
            report_mismatch($sformatf("count_after got %0d want %0d",
                                      out_i.count_after, want.count_after));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_heap_op(in_i, pred);
        pending_results = {pending_results, pred};
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
// Top of the max-heap priority queue bench: clock, reset, stimulus and verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and mhpq_checker.
module testbench import mhpq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int HOLD_CYCLES = 500;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   err_cnt;
  int   seen_cnt;
  int   sent_cnt     = 0;
  int   occupancy    = 0;
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   cycle_cnt    = 0;
  logic hold_tog     = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  max_heap_priority_queue u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  mhpq_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_i        (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_i       (out_data),
    .err_cnt_o   (err_cnt),
    .seen_cnt_o  (seen_cnt)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $signed($urandom_range(0, 8)) - 4;   // dense keys, plenty of ties
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(input func_e f, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.func  <= f;
    in_data.value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt = sent_cnt + 1;
    if (f == FUNC_INSERT) begin
      if (occupancy < CAPACITY) occupancy = occupancy + 1;
    end else if (occupancy > 0) begin
      occupancy = occupancy - 1;
    end
  endtask

  task automatic send_random(input int n_items, input int insert_pct);
    repeat (n_items) begin
      if ($urandom_range(0, 99) < insert_pct) send_item(FUNC_INSERT, pick_value());
      else send_item(FUNC_DELETE, $urandom);
    end
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty delete, extreme keys, ties, full drain
    send_item(FUNC_DELETE, 32'sh7FFF_FFFF);
    send_item(FUNC_INSERT, 0);
    send_item(FUNC_INSERT, 32'sh7FFF_FFFF);
    send_item(FUNC_INSERT, 32'sh8000_0000);
    send_item(FUNC_INSERT, -1);
    send_item(FUNC_INSERT, 1);
    send_item(FUNC_INSERT, 5);
    send_item(FUNC_INSERT, 5);
    send_item(FUNC_INSERT, 5);
    repeat (8) send_item(FUNC_DELETE, $urandom);
    send_item(FUNC_DELETE, -1);
    send_item(FUNC_INSERT, 3);
    send_item(FUNC_INSERT, 3);
    send_item(FUNC_INSERT, 3);
    send_item(FUNC_DELETE, 0);

    // light gaps on both sides
    snd_idle_pct  = 9;
    rcv_stall_pct = 9;
    send_random(150, 50);

    // no idling: fill to capacity, long receiver hold-off on the way
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    n = 0;
    while (occupancy < CAPACITY) begin
      if (n == 400) hold_tog <= ~hold_tog;
      if ($urandom_range(0, 99) < 90) send_item(FUNC_INSERT, pick_value());
      else send_item(FUNC_DELETE, $urandom);
      n = n + 1;
    end
    repeat (6) send_item(FUNC_INSERT, pick_value());
    repeat (4) begin
      send_item(FUNC_DELETE, $urandom);
      send_item(FUNC_INSERT, pick_value());
      send_item(FUNC_INSERT, pick_value());
    end

    snd_idle_pct  = 76;
    rcv_stall_pct = 0;
    send_random(130, 35);

    snd_idle_pct  = 0;
    rcv_stall_pct = 76;
    send_random(130, 55);

    in_valid <= 1'b0;
    while (seen_cnt < sent_cnt) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ max_heap_priority_queue.f @@
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/mhpq_seq.sv
sv/max_heap_priority_queue.sv
bench/mhpq_checker.sv
bench/testbench.sv
